[rtl/cmb_enum_pkg.sv]
package cmb_enum_pkg;

    // Field widths
    localparam int ELEM_W    = 5;
    localparam int SET_W     = 6;
    localparam int PICK_W    = 5;
    localparam int CFG_IDX_W = 2;

    typedef logic [ELEM_W-1:0]    t_elem;
    typedef logic [SET_W-1:0]     t_set;
    typedef logic [PICK_W-1:0]    t_pick;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx CFG_SET_SIZE   = 2'd0;
    localparam t_cfg_idx CFG_PICK_COUNT = 2'd1;

    // Register reset values
    localparam t_set  SET_SIZE_RST   = 6'd4;
    localparam t_pick PICK_COUNT_RST = 5'd2;

    // Controller to datapath
    typedef struct packed {
        logic cfg_open;    // config port may write
        logic capture;     // item taken: latch carry vector, clear element count
        logic load_first;  // members <= 0,1,2,...
        logic advance;     // step members to next colex combination
        logic emit;        // load output register with current element
        logic flag;        // load output register with the flagged result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cfg_hit;     // write to a known register is offered
        logic invalid;     // setup cannot give any combination
        logic found;       // some member can still be stepped
        logic out_free;    // output register can take a result
        logic last;        // element count is at the last member
    } t_status;

endpackage

[rtl/cmb_enum_ctrl.sv]
module cmb_enum_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_restart,
    output logic                  o_in_stall,
    input  cmb_enum_pkg::t_status i_status,
    output cmb_enum_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_FLAG = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_active, n_active;
    logic       r_exhausted, n_exhausted;
    logic       w_in_accept;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.cfg_open = (r_state == ST_IDLE);
        n_state        = r_state;
        n_active       = r_active;
        n_exhausted    = r_exhausted;
        case (r_state)
            ST_IDLE: begin
                if (i_status.cfg_hit) begin
                    n_active    = 1'b0;
                    n_exhausted = 1'b0;
                end
                if (w_in_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.invalid) begin
                        n_active    = 1'b0;
                        n_exhausted = 1'b0;
                        n_state     = ST_FLAG;
                    end else if (i_restart || !r_active) begin
                        o_cmd.load_first = 1'b1;
                        n_active         = 1'b1;
                        n_exhausted      = 1'b0;
                        n_state          = ST_EMIT;
                    end else if (r_exhausted) begin
                        n_state = ST_FLAG;
                    end else begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                if (i_status.found) begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_EMIT;
                end else begin
                    n_exhausted = 1'b1;
                    n_state     = ST_FLAG;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLAG: begin
                if (i_status.out_free) begin
                    o_cmd.flag = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_exhausted <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_exhausted <= n_exhausted;
        end
    end

endmodule

[rtl/cmb_enum_dp.sv]
module cmb_enum_dp #(
    parameter int MAX_SET  = 32,
    parameter int MAX_PICK = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cmb_enum_pkg::t_cmd     i_cmd,
    output cmb_enum_pkg::t_status  o_status,
    input  logic                   i_cfg_valid,
    input  cmb_enum_pkg::t_cfg_idx i_cfg_index,
    input  cmb_enum_pkg::t_set     i_cfg_data,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output cmb_enum_pkg::t_elem    o_element,
    output logic                   o_last_element,
    output logic                   o_final_combination,
    output logic                   o_no_combination
);

    localparam int MW = $clog2(MAX_SET);
    localparam int KW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int CW = 7;

    cmb_enum_pkg::t_set  r_set_size;
    cmb_enum_pkg::t_pick r_pick_count;
    logic [MW-1:0]       r_m [MAX_PICK];
    logic [MAX_PICK-1:0] r_cond;
    logic [KW-1:0]       r_k;

    logic                r_out_valid;
    cmb_enum_pkg::t_elem r_element;
    logic                r_last, r_fin, r_none;

    logic [MAX_PICK-1:0] w_cond, w_lowest, w_below;
    logic                w_cfg_we, w_last, w_fin, w_out_free;

    // Config registers
    assign w_cfg_we = i_cfg_valid && i_cmd.cfg_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size   <= cmb_enum_pkg::SET_SIZE_RST;
            r_pick_count <= cmb_enum_pkg::PICK_COUNT_RST;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                cmb_enum_pkg::CFG_SET_SIZE:   r_set_size   <= i_cfg_data;
                cmb_enum_pkg::CFG_PICK_COUNT: r_pick_count <= i_cfg_data[cmb_enum_pkg::PICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-lane carry test: m[i] may step if m[i]+1 < m[i+1], or < set size for the top
    for (genvar gi = 0; gi < MAX_PICK; gi++) begin : g_lane
        logic [CW-1:0] w_limit;
        if (gi == MAX_PICK - 1) begin : g_top
            assign w_limit = CW'(r_set_size);
        end else begin : g_mid
            assign w_limit = (CW'(gi + 1) < CW'(r_pick_count)) ? CW'(r_m[gi + 1])
                                                                : CW'(r_set_size);
        end
        assign w_cond[gi] = (CW'(gi) < CW'(r_pick_count)) &&
                            ((CW'(r_m[gi]) + CW'(1)) < w_limit);
    end

    // Lowest steppable lane, and the lanes below it that reset to 0,1,...
    assign w_lowest = r_cond & (~r_cond + MAX_PICK'(1));
    assign w_below  = w_lowest - MAX_PICK'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cond <= w_cond;
        end
        for (int j = 0; j < MAX_PICK; j++) begin
            if (i_cmd.load_first) begin
                r_m[j] <= MW'(j);
            end else if (i_cmd.advance) begin
                if (w_below[j]) begin
                    r_m[j] <= MW'(j);
                end else if (w_lowest[j]) begin
                    r_m[j] <= r_m[j] + MW'(1);
                end
            end
        end
    end

    // Element counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.capture) begin
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + KW'(1);
        end
    end

    assign w_last     = (cmb_enum_pkg::PICK_W'(r_k) == (r_pick_count - cmb_enum_pkg::PICK_W'(1)));
    assign w_fin      = (CW'(r_m[0]) == (CW'(r_set_size) - CW'(r_pick_count)));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.flag) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_element <= cmb_enum_pkg::t_elem'(r_m[r_k]);
            r_last    <= w_last;
            r_fin     <= w_fin;
            r_none    <= 1'b0;
        end else if (i_cmd.flag) begin
            r_element <= '0;
            r_last    <= 1'b1;
            r_fin     <= 1'b0;
            r_none    <= 1'b1;
        end
    end

    // Status
    always_comb begin
        o_status          = '0;
        o_status.cfg_hit  = i_cfg_valid &&
                            ((i_cfg_index == cmb_enum_pkg::CFG_SET_SIZE) ||
                             (i_cfg_index == cmb_enum_pkg::CFG_PICK_COUNT));
        o_status.invalid  = (r_pick_count == '0) ||
                            (CW'(r_pick_count) > CW'(r_set_size)) ||
                            (CW'(r_pick_count) > CW'(MAX_PICK)) ||
                            (CW'(r_set_size) > CW'(MAX_SET));
        o_status.found    = |r_cond;
        o_status.out_free = w_out_free;
        o_status.last     = w_last;
    end

    assign o_out_valid         = r_out_valid;
    assign o_element           = r_element;
    assign o_last_element      = r_last;
    assign o_final_combination = r_fin;
    assign o_no_combination    = r_none;

endmodule

[rtl/combination_enumerator.sv]
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_restart
// result    out        o_valid / i_stall    o_element, o_last_element,
//                                           o_final_combination, o_no_combination
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A restart, or an advance with nothing issued, loads the first combination and emits
// its p elements; an advance steps the members first; a flag may follow a failed advance.
// The carry test over all members runs in parallel lanes and is registered
// when the request is taken; the step itself is one masked update.
// Synchronous active-low reset: n = 4, p = 2, no combination issued.
// o_stall is high from the cycle after a request is taken until its last
// result is loaded; a stall on the result side holds the output register.
module combination_enumerator #(
    parameter int MAX_SET  = 32,
    parameter int MAX_PICK = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_restart,
    output logic                   o_valid,
    input  logic                   i_stall,
    output cmb_enum_pkg::t_elem    o_element,
    output logic                   o_last_element,
    output logic                   o_final_combination,
    output logic                   o_no_combination,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  cmb_enum_pkg::t_cfg_idx i_cfg_index,
    input  cmb_enum_pkg::t_set     i_cfg_data
);

    cmb_enum_pkg::t_cmd    w_cmd;
    cmb_enum_pkg::t_status w_status;

    assign o_cfg_ready = w_cmd.cfg_open;

    cmb_enum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_restart  (i_restart),
        .o_in_stall (o_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cmb_enum_dp #(
        .MAX_SET  (MAX_SET),
        .MAX_PICK (MAX_PICK)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_stall         (i_stall),
        .o_out_valid         (o_valid),
        .o_element           (o_element),
        .o_last_element      (o_last_element),
        .o_final_combination (o_final_combination),
        .o_no_combination    (o_no_combination)
    );

endmodule

[rtl/cmb_enum_chk.sv]
module cmb_enum_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   i_restart,
    input logic                   o_valid,
    input logic                   i_stall,
    input cmb_enum_pkg::t_elem    o_element,
    input logic                   o_last_element,
    input logic                   o_final_combination,
    input logic                   o_no_combination,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input cmb_enum_pkg::t_cfg_idx i_cfg_index,
    input cmb_enum_pkg::t_set     i_cfg_data
);

    // Flagged result carries element 0, last set, final clear
    a_flag_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_combination |->
            (o_element == 5'd0) && o_last_element && !o_final_combination)
        else $error("flagged result malformed");

    // One request at a time: a taken item closes the request port
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while busy");

    // Config port open exactly when the request port is
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_stall)
        else $error("config port open while busy");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_element) &&
            $stable(o_last_element) && $stable(o_no_combination))
        else $error("stalled result changed");

endmodule

bind combination_enumerator cmb_enum_chk u_cmb_enum_chk (.*);
